[hdl/sdlr_pkg.sv]
// Shared types and constants of the shuffled dual-LCG random generator.
// Used by the multiply-reduce unit, the shuffle table and the top level.
package sdlr_pkg;

  // Generator word and shared multiplier widths
  localparam int VAL_W  = 31;
  localparam int OPB_W  = 16;
  localparam int PROD_W = VAL_W + OPB_W;

  // Moduli, multipliers and the folding constants (2^31 mod modulus)
  localparam logic [VAL_W-1:0] MOD_A       = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD_B       = 31'd2147483399;
  localparam logic [VAL_W-1:0] MOD_A_LESS1 = 31'd2147483562;
  localparam logic [OPB_W-1:0] MUL_A       = 16'd40014;
  localparam logic [OPB_W-1:0] MUL_B       = 16'd40692;
  localparam logic [7:0]       FOLD_A      = 8'd85;
  localparam logic [7:0]       FOLD_B      = 8'd249;

  // Reset values of the generators
  localparam logic [VAL_W-1:0] FIRST_RESET  = 31'd1;
  localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

  // Modulus select codes
  localparam logic SEL_GEN_A = 1'b0;
  localparam logic SEL_GEN_B = 1'b1;

  // Command to the shared multiply-reduce unit
  typedef struct packed {
    logic [VAL_W-1:0] op_a;
    logic [OPB_W-1:0] op_b;
    logic             sel;
  } mm_cmd_t;

endpackage

[hdl/sdlr_mulmod.sv]
// Shared multiply-reduce unit: registered 31x16 product, then a fold
// into the selected modulus. Depends on sdlr_pkg.
module sdlr_mulmod
  import sdlr_pkg::*;
(
  input  logic              clk,
  input  mm_cmd_t           cmd,
  output logic [PROD_W-1:0] prod,
  output logic [VAL_W-1:0]  residue
);

  logic [PROD_W-1:0] prod_r;
  logic              sel_r;
  logic [OPB_W-1:0]  hi;
  logic [VAL_W-1:0]  lo;
  logic [31:0]       sum;
  logic [31:0]       modv;

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(cmd.op_a) * PROD_W'(cmd.op_b);
    sel_r  <= cmd.sel;
  end

  // Fold the high part with 2^31 mod m, then one conditional subtract
  always_comb begin
    hi = prod_r[PROD_W-1:VAL_W];
    lo = prod_r[VAL_W-1:0];
    if (sel_r == SEL_GEN_B) begin
      sum  = 32'(lo) + 32'(hi) * 32'(FOLD_B);
      modv = 32'(MOD_B);
    end else begin
      sum  = 32'(lo) + 32'(hi) * 32'(FOLD_A);
      modv = 32'(MOD_A);
    end
    if (sum >= modv) begin
      residue = VAL_W'(sum - modv);
    end else begin
      residue = sum[VAL_W-1:0];
    end
  end

  assign prod = prod_r;

endmodule

[hdl/sdlr_table.sv]
// Shuffle table: one-write, one-read memory with registered read data
// and per-entry valid bits so unwritten entries read as zero. Uses sdlr_pkg.
module sdlr_table
  import sdlr_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [VAL_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [VAL_W-1:0] rd_data_r;
  logic             rd_hit_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits, cleared on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_hit_r  <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

[hdl/shuffled_dual_lcg_random_top.sv]
// Shuffled dual-LCG random generator, top level with the sequencer.
// A draw runs MUL_X, FOLD_X, FOLD_Y, QUOT, SLOT and MIX, and its result is
// registered into out_draw; a reseed first runs a warm-up that fills the table.
// One transaction at a time: in_stall is high outside IDLE, and MIX waits for a
// free output register. All multiplies share one unit (multiply stage, fold).
// Reset: generators return to 1 and 123456789, last output and table to zero.
module shuffled_dual_lcg_random_top
  import sdlr_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [30:0]      in_seed,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [30:0]      out_draw
);

  // Derived sizes and the slot divider with its reciprocal
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 8);
  localparam int QW = $clog2(TABLE_DEPTH + 2);
  localparam logic [63:0] SLOT_DIV_W =
    64'd1 + (64'(MOD_A) - 64'd2) / 64'(TABLE_DEPTH);
  localparam logic [63:0] RECIP_W = (64'd1 << VAL_W) / SLOT_DIV_W;
  localparam logic [VAL_W-1:0] SLOT_DIV = SLOT_DIV_W[VAL_W-1:0];
  localparam logic [OPB_W-1:0] RECIP    = RECIP_W[OPB_W-1:0];

  // Sequencer states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_WARM_MUL  = 4'd1;
  localparam logic [3:0] ST_WARM_FOLD = 4'd2;
  localparam logic [3:0] ST_MUL_X     = 4'd3;
  localparam logic [3:0] ST_FOLD_X    = 4'd4;
  localparam logic [3:0] ST_FOLD_Y    = 4'd5;
  localparam logic [3:0] ST_QUOT      = 4'd6;
  localparam logic [3:0] ST_SLOT      = 4'd7;
  localparam logic [3:0] ST_MIX       = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [VAL_W-1:0]  x_r, x_nxt;
  logic [VAL_W-1:0]  y_r, y_nxt;
  logic [VAL_W-1:0]  last_r, last_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [QW-1:0]     q0_r, q0_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_draw_r, out_draw_nxt;

  mm_cmd_t           cmd;
  logic [PROD_W-1:0] prod;
  logic [VAL_W-1:0]  residue;

  logic              tbl_rd_en;
  logic [VAL_W-1:0]  tbl_rd_data;
  logic              tbl_wr_en;
  logic [AW-1:0]     tbl_wr_addr;
  logic [VAL_W-1:0]  tbl_wr_data;

  logic              in_fire;
  logic              out_fire;
  logic              can_emit;
  logic [31:0]       rem;
  logic [QW-1:0]     q_fix;
  logic [31:0]       mix;
  logic [VAL_W-1:0]  seed_eff;

  sdlr_mulmod u_mulmod (
    .clk     (clk),
    .cmd     (cmd),
    .prod    (prod),
    .residue (residue)
  );

  sdlr_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (tbl_rd_en),
    .rd_addr (slot_nxt),
    .rd_data (tbl_rd_data),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data)
  );

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign can_emit = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign seed_eff = (in_seed == '0) ? VAL_W'(1) : in_seed;

  // Slot correction: remainder against the divider; the clamp follows in ST_SLOT
  always_comb begin
    rem   = {1'b0, last_r} - prod[31:0];
    q_fix = (rem >= 32'(SLOT_DIV)) ? q0_r + QW'(1) : q0_r;
  end

  // Shuffled output: slot value minus second generator, wrapped into range
  always_comb begin
    if (tbl_rd_data > y_r) begin
      mix = 32'(tbl_rd_data) - 32'(y_r);
    end else begin
      mix = 32'(tbl_rd_data) + (32'(MOD_A_LESS1) - 32'(y_r));
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    q0_nxt        = q0_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_draw_nxt  = out_draw_r;
    cmd.op_a      = x_r;
    cmd.op_b      = MUL_A;
    cmd.sel       = SEL_GEN_A;
    tbl_rd_en     = 1'b0;
    tbl_wr_en     = 1'b0;
    tbl_wr_addr   = slot_r;
    tbl_wr_data   = x_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action) begin
            x_nxt     = seed_eff;
            y_nxt     = seed_eff;
            cnt_nxt   = CW'(TABLE_DEPTH + 7);
            state_nxt = ST_WARM_MUL;
          end else begin
            state_nxt = ST_MUL_X;
          end
        end
      end
      ST_WARM_MUL: begin
        // issue first generator step (default command)
        state_nxt = ST_WARM_FOLD;
      end
      ST_WARM_FOLD: begin
        // advance, fill the table from the top slot down
        x_nxt = residue;
        if (cnt_r < CW'(TABLE_DEPTH)) begin
          tbl_wr_en   = 1'b1;
          tbl_wr_addr = cnt_r[AW-1:0];
          tbl_wr_data = residue;
        end
        if (cnt_r == '0) begin
          last_nxt  = residue;
          state_nxt = ST_MUL_X;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_WARM_MUL;
        end
      end
      ST_MUL_X: begin
        state_nxt = ST_FOLD_X;
      end
      ST_FOLD_X: begin
        x_nxt     = residue;
        cmd.op_a  = y_r;
        cmd.op_b  = MUL_B;
        cmd.sel   = SEL_GEN_B;
        state_nxt = ST_FOLD_Y;
      end
      ST_FOLD_Y: begin
        // estimate slot = last / divider through the reciprocal
        y_nxt     = residue;
        cmd.op_a  = last_r;
        cmd.op_b  = RECIP;
        state_nxt = ST_QUOT;
      end
      ST_QUOT: begin
        q0_nxt    = prod[VAL_W+QW-1:VAL_W];
        cmd.op_a  = SLOT_DIV;
        cmd.op_b  = OPB_W'(prod[VAL_W+QW-1:VAL_W]);
        state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        if (q_fix >= QW'(TABLE_DEPTH)) begin
          slot_nxt = AW'(TABLE_DEPTH - 1);
        end else begin
          slot_nxt = q_fix[AW-1:0];
        end
        tbl_rd_en = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        // hold until the output register frees up
        if (can_emit) begin
          last_nxt      = mix[VAL_W-1:0];
          out_draw_nxt  = mix[VAL_W-1:0];
          out_valid_nxt = 1'b1;
          tbl_wr_en     = 1'b1;
          tbl_wr_addr   = slot_r;
          tbl_wr_data   = x_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      x_r         <= FIRST_RESET;
      y_r         <= SECOND_RESET;
      last_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q0_r       <= q0_nxt;
    slot_r     <= slot_nxt;
    out_draw_r <= out_draw_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_draw  = out_draw_r;

endmodule
